@@ rtl/dop_pkg.sv @@
package dop_pkg;

   // Field widths of one request byte and one parse result
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned ClassWidth = 2;
   localparam int unsigned AddrWidth  = 32;

   // Option codes
   localparam logic [ByteWidth-1:0] CodePad     = 8'h00;
   localparam logic [ByteWidth-1:0] CodeEnd     = 8'hff;
   localparam logic [ByteWidth-1:0] CodeType    = 8'd53;
   localparam logic [ByteWidth-1:0] CodeServer  = 8'd54;
   localparam logic [ByteWidth-1:0] CodeRequest = 8'd50;

   // Message type values of option 53
   localparam logic [ByteWidth-1:0] TypeDiscover = 8'd1;
   localparam logic [ByteWidth-1:0] TypeOffer    = 8'd2;
   localparam logic [ByteWidth-1:0] TypeRequest  = 8'd3;

   // Message classes
   localparam logic [ClassWidth-1:0] ClassDiscover = 2'd0;
   localparam logic [ClassWidth-1:0] ClassRequest  = 2'd1;
   localparam logic [ClassWidth-1:0] ClassOffer    = 2'd2;
   localparam logic [ClassWidth-1:0] ClassOther    = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_CODE = 2'd1,
      PH_LEN  = 2'd2,
      PH_VAL  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_SKIP    = 2'd0,
      KIND_TYPE    = 2'd1,
      KIND_SERVER  = 2'd2,
      KIND_REQUEST = 2'd3
   } kind_type;

   // Seen flags of the captured options
   typedef struct packed {
      logic request;
      logic server;
      logic mtype;
   } seen_type;

   // Classify a message from its captured type option
   function automatic logic [ClassWidth-1:0] class_of(input logic seen,
                                                       input logic [ByteWidth-1:0] mtype);
      logic [ClassWidth-1:0] cls;
      cls = ClassOther;
      if (seen) begin
         unique case (mtype)
            TypeDiscover: cls = ClassDiscover;
            TypeRequest:  cls = ClassRequest;
            TypeOffer:    cls = ClassOffer;
            default:      cls = ClassOther;
         endcase
      end
      return cls;
   endfunction

endpackage

@@ rtl/dop_req_if.sv @@
interface dop_req_if;
   logic                            valid;
   logic                            ready;
   logic [dop_pkg::ByteWidth-1:0]   opt_byte;
   logic                            start_req;

   modport source (output valid, output opt_byte, output start_req, input ready);
   modport sink   (input valid, input opt_byte, input start_req, output ready);
endinterface

@@ rtl/dop_rsp_if.sv @@
interface dop_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dop_pkg::ClassWidth-1:0]  msg_class;
   logic [dop_pkg::ByteWidth-1:0]   msg_type;
   logic                            type_seen;
   logic [dop_pkg::AddrWidth-1:0]   server_id;
   logic                            server_id_seen;
   logic [dop_pkg::AddrWidth-1:0]   requested_ip;
   logic                            requested_ip_seen;

   modport source (output valid, output msg_class, output msg_type, output type_seen,
                   output server_id, output server_id_seen, output requested_ip,
                   output requested_ip_seen, input ready);
   modport sink   (input valid, input msg_class, input msg_type, input type_seen,
                   input server_id, input server_id_seen, input requested_ip,
                   input requested_ip_seen, output ready);
endinterface

@@ rtl/dhcp_option_parser.sv @@
// DHCP options parser.
// The request channel (req_ch) carries the options area one byte per request,
// with start_req set on the first byte of each message; that byte clears all
// captures and is parsed as an option code. Option 53 (message type), 54
// (server identifier) and 50 (requested address) are captured, every other
// option is skipped by its length, pad is a single byte. The end code gives
// one result on the response channel (rsp_ch); bytes after it are ignored
// until the next start.
// A byte accepted into the input register is parsed on its way to the
// result register, and an end code shows its result on rsp_ch from there.
// Throughput: one byte per cycle, set by the single pass through the parser
// state update, while no end code waits on a full output register.
// When the receiver stalls, the result is held in the output register; bytes
// that give no result keep flowing, and the pipeline stops only when a second
// end code meets a full output register.
// Reset (synchronous, active high) returns the parser to idle with all
// captures cleared and empties both registers.
module dhcp_option_parser (
   input  logic            clock,
   input  logic            reset,
   dop_req_if.sink         req_ch,
   dop_rsp_if.source       rsp_ch
);

   // Input register
   logic                              in_valid_ff;
   logic [dop_pkg::ByteWidth-1:0]     in_byte_ff;
   logic                              in_start_ff;

   // Parser state
   dop_pkg::phase_type                phase_ff, phase_in;
   logic [dop_pkg::ByteWidth-1:0]     left_ff, left_in;
   dop_pkg::kind_type                 kind_ff, kind_in;
   logic [dop_pkg::ByteWidth-1:0]     type_ff, type_in;
   logic [dop_pkg::AddrWidth-1:0]     server_ff, server_in;
   logic [dop_pkg::AddrWidth-1:0]     reqip_ff, reqip_in;
   dop_pkg::seen_type                 seen_ff, seen_in;

   // Result register
   logic                              out_valid_ff;
   logic [dop_pkg::ClassWidth-1:0]    out_class_ff;
   logic [dop_pkg::ByteWidth-1:0]     out_type_ff;
   logic [dop_pkg::AddrWidth-1:0]     out_server_ff;
   logic [dop_pkg::AddrWidth-1:0]     out_reqip_ff;
   dop_pkg::seen_type                 out_seen_ff;

   logic                              is_end;
   logic                              advance;
   logic                              out_free;

   // Parse one byte from the registered request
   always_comb begin
      dop_pkg::phase_type ph;
      ph        = phase_ff;
      left_in   = left_ff;
      kind_in   = kind_ff;
      type_in   = type_ff;
      server_in = server_ff;
      reqip_in  = reqip_ff;
      seen_in   = seen_ff;
      is_end    = 1'b0;

      // Clear captures on start and treat this byte as a code
      if (in_start_ff) begin
         ph        = dop_pkg::PH_CODE;
         left_in   = '0;
         kind_in   = dop_pkg::KIND_SKIP;
         type_in   = '0;
         server_in = '0;
         reqip_in  = '0;
         seen_in   = '0;
      end
      phase_in = ph;

      unique case (ph)
         dop_pkg::PH_CODE: begin
            priority if (in_byte_ff == dop_pkg::CodeEnd) begin
               is_end   = 1'b1;
               phase_in = dop_pkg::PH_IDLE;
            end else if (in_byte_ff == dop_pkg::CodePad) begin
               phase_in = dop_pkg::PH_CODE;
            end else begin
               unique case (in_byte_ff)
                  dop_pkg::CodeType:    kind_in = dop_pkg::KIND_TYPE;
                  dop_pkg::CodeServer:  kind_in = dop_pkg::KIND_SERVER;
                  dop_pkg::CodeRequest: kind_in = dop_pkg::KIND_REQUEST;
                  default:              kind_in = dop_pkg::KIND_SKIP;
               endcase
               phase_in = dop_pkg::PH_LEN;
            end
         end
         dop_pkg::PH_LEN: begin
            left_in = in_byte_ff;
            if (in_byte_ff == '0) begin
               phase_in = dop_pkg::PH_CODE;
            end else begin
               unique case (kind_in)
                  dop_pkg::KIND_TYPE: begin
                     type_in       = '0;
                     seen_in.mtype = 1'b1;
                  end
                  dop_pkg::KIND_SERVER: begin
                     server_in      = '0;
                     seen_in.server = 1'b1;
                  end
                  dop_pkg::KIND_REQUEST: begin
                     reqip_in        = '0;
                     seen_in.request = 1'b1;
                  end
                  default: ;
               endcase
               phase_in = dop_pkg::PH_VAL;
            end
         end
         dop_pkg::PH_VAL: begin
            unique case (kind_in)
               dop_pkg::KIND_TYPE:    type_in   = in_byte_ff;
               dop_pkg::KIND_SERVER:  server_in = {server_ff[dop_pkg::AddrWidth-
                                                   dop_pkg::ByteWidth-1:0], in_byte_ff};
               dop_pkg::KIND_REQUEST: reqip_in  = {reqip_ff[dop_pkg::AddrWidth-
                                                   dop_pkg::ByteWidth-1:0], in_byte_ff};
               default: ;
            endcase
            left_in = left_ff - dop_pkg::ByteWidth'(1);
            if (left_in == '0) begin
               phase_in = dop_pkg::PH_CODE;
            end
         end
         default: ;
      endcase
   end

   // Hold a byte only when its result cannot enter a full output register
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && (!is_end || out_free);
   assign req_ch.ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff  <= req_ch.opt_byte;
         in_start_ff <= req_ch.start_req;
      end
   end

   // Parser state update
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= dop_pkg::PH_IDLE;
         left_ff   <= '0;
         kind_ff   <= dop_pkg::KIND_SKIP;
         type_ff   <= '0;
         server_ff <= '0;
         reqip_ff  <= '0;
         seen_ff   <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         kind_ff   <= kind_in;
         type_ff   <= type_in;
         server_ff <= server_in;
         reqip_ff  <= reqip_in;
         seen_ff   <= seen_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && is_end) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && is_end) begin
         out_class_ff  <= dop_pkg::class_of(seen_in.mtype, type_in);
         out_type_ff   <= type_in;
         out_server_ff <= server_in;
         out_reqip_ff  <= reqip_in;
         out_seen_ff   <= seen_in;
      end
   end

   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.msg_class         = out_class_ff;
   assign rsp_ch.msg_type          = out_type_ff;
   assign rsp_ch.type_seen         = out_seen_ff.mtype;
   assign rsp_ch.server_id         = out_server_ff;
   assign rsp_ch.server_id_seen    = out_seen_ff.server;
   assign rsp_ch.requested_ip      = out_reqip_ff;
   assign rsp_ch.requested_ip_seen = out_seen_ff.request;

endmodule

@@ tb/tb_dhcp_option_parser.sv @@
`timescale 1ns / 100ps

module tb_dhcp_option_parser;
   import dop_pkg::*;

   localparam int unsigned IdleLimit   = 2000;
   localparam int unsigned RandomBytes = 900;
   localparam int unsigned DrainCycles = 20;

   typedef logic [ByteWidth-1:0] opt_bytes_type[$];

   typedef struct packed {
      logic [ClassWidth-1:0] msg_class;
      logic [ByteWidth-1:0]  msg_type;
      logic                  type_seen;
      logic [AddrWidth-1:0]  server_id;
      logic                  server_id_seen;
      logic [AddrWidth-1:0]  requested_ip;
      logic                  requested_ip_seen;
   } lease_info_type;

   logic clock;
   logic reset;

   dop_req_if req_ch ();
   dop_rsp_if rsp_ch ();

   dhcp_option_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Parser shadow state
   phase_type            parse_phase = PH_IDLE;
   kind_type             opt_kind    = KIND_SKIP;
   logic [ByteWidth-1:0] value_left  = '0;
   logic [ByteWidth-1:0] type_cap    = '0;
   logic [AddrWidth-1:0] server_cap  = '0;
   logic [AddrWidth-1:0] request_cap = '0;
   seen_type             seen_cap    = '0;

   lease_info_type pending_leases[$];
   int unsigned  error_count = 0;
   int unsigned  idle_cycles = 0;
   int unsigned  msg_bytes_sent = 0;
   bit           quiet = 1'b0;

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // Advance the shadow parser by one accepted byte; queue a lease on the end code
   function automatic void track_option_byte(input logic [ByteWidth-1:0] b, input logic s);
      lease_info_type lease;
      if (s) begin
         value_left  = '0;
         opt_kind    = KIND_SKIP;
         type_cap    = '0;
         server_cap  = '0;
         request_cap = '0;
         seen_cap    = '0;
         parse_phase = PH_CODE;
      end
      case (parse_phase)
         PH_CODE: begin
            if (b == CodeEnd) begin
               lease.msg_class = ClassOther;
               if (seen_cap.mtype) begin
                  if (type_cap == TypeDiscover) lease.msg_class = ClassDiscover;
                  else if (type_cap == TypeRequest) lease.msg_class = ClassRequest;
                  else if (type_cap == TypeOffer) lease.msg_class = ClassOffer;
               end
               lease.msg_type          = type_cap;
               lease.type_seen         = seen_cap.mtype;
               lease.server_id         = server_cap;
               lease.server_id_seen    = seen_cap.server;
               lease.requested_ip      = request_cap;
               lease.requested_ip_seen = seen_cap.request;
               pending_leases.push_back(lease);
               parse_phase = PH_IDLE;
            end else if (b != CodePad) begin
               if (b == CodeType) opt_kind = KIND_TYPE;
               else if (b == CodeServer) opt_kind = KIND_SERVER;
               else if (b == CodeRequest) opt_kind = KIND_REQUEST;
               else opt_kind = KIND_SKIP;
               parse_phase = PH_LEN;
            end
         end
         PH_LEN: begin
            value_left = b;
            if (b == '0) begin
               parse_phase = PH_CODE;
            end else begin
               case (opt_kind)
                  KIND_TYPE: begin
                     type_cap = '0;
                     seen_cap.mtype = 1'b1;
                  end
                  KIND_SERVER: begin
                     server_cap = '0;
                     seen_cap.server = 1'b1;
                  end
                  KIND_REQUEST: begin
                     request_cap = '0;
                     seen_cap.request = 1'b1;
                  end
                  default: ;
               endcase
               parse_phase = PH_VAL;
            end
         end
         PH_VAL: begin
            case (opt_kind)
               KIND_TYPE:    type_cap = b;
               KIND_SERVER:  server_cap = {server_cap[AddrWidth-ByteWidth-1:0], b};
               KIND_REQUEST: request_cap = {request_cap[AddrWidth-ByteWidth-1:0], b};
               default: ;
            endcase
            value_left = value_left - ByteWidth'(1);
            if (value_left == '0) parse_phase = PH_CODE;
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(input string name, input logic [AddrWidth-1:0] want,
                                         input logic [AddrWidth-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         error_count++;
      end
   endfunction

   // Match one delivered lease against the oldest one predicted
   function automatic void check_lease();
      lease_info_type want;
      if (pending_leases.size() == 0) begin
         $error("result with no lease pending: class %0d type %0h",
                rsp_ch.msg_class, rsp_ch.msg_type);
         error_count++;
         return;
      end
      want = pending_leases.pop_front();
      compare_field("msg_class", AddrWidth'(want.msg_class), AddrWidth'(rsp_ch.msg_class));
      compare_field("msg_type", AddrWidth'(want.msg_type), AddrWidth'(rsp_ch.msg_type));
      compare_field("type_seen", AddrWidth'(want.type_seen), AddrWidth'(rsp_ch.type_seen));
      compare_field("server_id", want.server_id, rsp_ch.server_id);
      compare_field("server_id_seen", AddrWidth'(want.server_id_seen),
                    AddrWidth'(rsp_ch.server_id_seen));
      compare_field("requested_ip", want.requested_ip, rsp_ch.requested_ip);
      compare_field("requested_ip_seen", AddrWidth'(want.requested_ip_seen),
                    AddrWidth'(rsp_ch.requested_ip_seen));
   endfunction

   // Watch both handshakes at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) track_option_byte(req_ch.opt_byte, req_ch.start_req);
         if (rsp_ch.valid && rsp_ch.ready) check_lease();
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // Stop a hung run
   initial begin
      wait (idle_cycles >= IdleLimit);
      $display("FAILURE");
      $finish;
   end

   // Receiver: random stalls, none while quiet
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Send one request; entered and left at a falling edge
   task automatic send_byte(input logic [ByteWidth-1:0] b, input logic s);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     = 1'b1;
      req_ch.opt_byte  = b;
      req_ch.start_req = s;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Send a message with start on its first byte
   task automatic send_message(input opt_bytes_type msg);
      foreach (msg[i]) send_byte(msg[i], i == 0);
      msg_bytes_sent += msg.size();
   endtask

   // Append one option with a mostly usual length and random content
   function automatic void add_option(ref opt_bytes_type msg, input logic [ByteWidth-1:0] code);
      int unsigned len;
      int unsigned r;
      msg.push_back(code);
      if (code == CodePad) return;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         if (code == CodeType) len = 1;
         else if (code == CodeServer || code == CodeRequest) len = 4;
         else len = $urandom_range(0, 6);
      end else if (r < 97) begin
         len = $urandom_range(0, 8);
      end else begin
         len = $urandom_range(0, 255);
      end
      msg.push_back(len[ByteWidth-1:0]);
      for (int i = 0; i < len; i++) begin
         if (code == CodeType && $urandom_range(0, 3) != 0)
            msg.push_back(ByteWidth'($urandom_range(TypeDiscover, TypeRequest)));
         else
            msg.push_back(ByteWidth'($urandom_range(0, 255)));
      end
   endfunction

   // Bytes outside a message must be dropped
   task automatic test_idle_bytes();
      send_byte(CodeEnd, 1'b0);
      send_byte(CodeType, 1'b0);
      send_message('{CodeEnd});
   endtask

   // Pad, discover, all-ones and all-zeros addresses, end code as data
   task automatic test_plain_capture();
      send_message('{CodePad, CodeType, 8'd1, TypeDiscover,
                     CodeServer, 8'd4, 8'hff, 8'hff, 8'hff, 8'hff,
                     CodeRequest, 8'd4, 8'h00, 8'h00, 8'h00, 8'h00, CodeEnd});
   endtask

   // Unusual lengths keep the last bytes; zero length leaves the flag alone
   task automatic test_odd_lengths();
      send_message('{CodeType, 8'd2, 8'h07, TypeRequest,
                     CodeRequest, 8'd5, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
                     CodeRequest, 8'd0, CodeServer, 8'd0, CodeEnd});
   endtask

   // Drop an unfinished message on a new start; repeat overwrites; odd type
   task automatic test_restart();
      send_message('{CodeType, 8'd1, TypeOffer, CodeServer, 8'd4, 8'h0a});
      send_message('{CodeType, 8'd1, TypeOffer, CodeEnd});
      send_message('{CodeType, 8'd1, TypeOffer, CodeType, 8'd1, 8'h80, CodeEnd});
   endtask

   // Longest length byte on a captured option
   task automatic test_longest_option();
      opt_bytes_type msg;
      msg = '{CodeServer, 8'hff};
      repeat (255) msg.push_back(ByteWidth'($urandom_range(0, 255)));
      msg.push_back(CodeEnd);
      send_message(msg);
   endtask

   // Mostly well-formed messages, some cut short, some with junk or noise
   task automatic test_random_messages();
      opt_bytes_type msg;
      int unsigned first_byte;
      int unsigned r;
      first_byte = msg_bytes_sent;
      while (msg_bytes_sent - first_byte < RandomBytes) begin
         quiet = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 9) == 0) begin
            send_byte(ByteWidth'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            msg = {};
            repeat ($urandom_range(0, 5)) begin
               r = $urandom_range(0, 99);
               if (r < 10) add_option(msg, CodePad);
               else if (r < 35) add_option(msg, CodeType);
               else if (r < 55) add_option(msg, CodeServer);
               else if (r < 75) add_option(msg, CodeRequest);
               else add_option(msg, ByteWidth'($urandom_range(1, 254)));
            end
            if ($urandom_range(0, 99) < 85) msg.push_back(CodeEnd);
            if (msg.size() == 0) msg.push_back(ByteWidth'($urandom_range(0, 255)));
            send_message(msg);
            if ($urandom_range(0, 9) < 3) begin
               repeat ($urandom_range(1, 3)) send_byte(ByteWidth'($urandom_range(0, 255)), 1'b0);
            end
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.opt_byte  = '0;
      req_ch.start_req = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_bytes();
      test_plain_capture();
      test_odd_lengths();
      test_restart();
      test_longest_option();
      test_random_messages();
      req_ch.valid = 1'b0;

      // Drain outstanding leases, then allow for latency
      while (pending_leases.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
      if (pending_leases.size() != 0) begin
         $error("%0d leases never delivered", pending_leases.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
